>>> src/rsis_pkg.sv
`default_nettype none

package rsis_pkg;

  localparam int REG_IDX_W = 5;
  localparam int NUM_REGS  = 1 << REG_IDX_W;

  typedef logic [31:0]          word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam word_t RESET_VECTOR = 32'hBFC0_0000;
  localparam word_t REGION_MASK  = 32'hF000_0000;
  localparam word_t PC_STEP      = 32'd4;

  // primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_ADDI    = 6'h08;

  // SPECIAL function codes
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_AND = 6'h24;

  typedef struct packed {
    word_t    next_pc;
    logic     reg_written;
    reg_idx_t dest_index;
    word_t    write_value;
    logic     branch_taken;
    logic     handled;
  } result_t;

endpackage

`default_nettype wire

>>> src/rsis_chan_if.sv
`default_nettype none

interface rsis_in_if;
  logic                 valid;
  logic                 ready;
  rsis_pkg::word_t      instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rsis_out_if;
  logic                 valid;
  logic                 ready;
  rsis_pkg::word_t      next_pc;
  logic                 reg_written;
  rsis_pkg::reg_idx_t   dest_index;
  rsis_pkg::word_t      write_value;
  logic                 branch_taken;
  logic                 handled;

  modport source (output valid, output next_pc, output reg_written, output dest_index,
                  output write_value, output branch_taken, output handled, input ready);
  modport sink   (input valid, input next_pc, input reg_written, input dest_index,
                  input write_value, input branch_taken, input handled, output ready);
endinterface

`default_nettype wire

>>> src/risc_subset_instruction_step.sv
// Each accepted instruction passes the execute-stage register, then the output register.
// Throughput: one per cycle unless the output stalls; the registered register-file memory
//   read and a one-entry write bypass let dependent instructions run back to back.
// Reset (rst_n low, synchronous): PC goes to 0xBFC00000 and all 32 per-register valid
//   bits clear, so every register reads as zero at once; no clearing pass is needed.
`default_nettype none

module risc_subset_instruction_step (
  input  wire           clk,
  input  wire           rst_n,
  rsis_in_if.sink       in_ch,
  rsis_out_if.source    out_ch
);

  // ---------------------------------------------------------------
  // Register file: 32 x 32 memory, two registered read ports, one write
  // port. vld_r marks entries written since reset; unwritten reads zero.
  // Register zero is never written, so it always reads zero.
  // ---------------------------------------------------------------
  rsis_pkg::word_t                   rf_mem [rsis_pkg::NUM_REGS];
  logic [rsis_pkg::NUM_REGS-1:0]     vld_r;

  rsis_pkg::word_t    rf_rdata_a_r, rf_rdata_b_r;
  logic               rd_vld_a_r, rd_vld_b_r;
  rsis_pkg::reg_idx_t rd_addr_a, rd_addr_b;

  // execute stage (holds the instruction whose operands are being read)
  logic               s2_valid_r;
  rsis_pkg::word_t    s2_instr_r;

  // bypass of the write committed in the previous cycle
  logic               byp_valid_r;
  rsis_pkg::reg_idx_t byp_idx_r;
  rsis_pkg::word_t    byp_val_r;

  rsis_pkg::word_t    pc_r;

  // output register
  logic               out_valid_r;
  rsis_pkg::result_t  out_res_r;

  logic               in_fire;
  logic               commit;

  // execute signals
  logic [5:0]         opc, fn;
  rsis_pkg::reg_idx_t rs, rt, rdi;
  rsis_pkg::word_t    op_a, op_b, sext_imm, pc4;
  rsis_pkg::word_t    npc, val;
  rsis_pkg::reg_idx_t dst;
  logic               wr, taken, ok, wr_eff;
  rsis_pkg::result_t  res;

  // ---------------------------------------------------------------
  // Handshake: the execute stage moves into the output register whenever
  // that register is empty or being drained, so a waiting result blocks a
  // new request at the input only while the execute stage is also full.
  // ---------------------------------------------------------------
  assign commit       = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s2_valid_r || commit;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Read at the incoming instruction's sources; when the stage is stalled
  // re-read its own sources so data written meanwhile is picked up.
  assign rd_addr_a = in_fire ? in_ch.instr_word[25:21] : s2_instr_r[25:21];
  assign rd_addr_b = in_fire ? in_ch.instr_word[20:16] : s2_instr_r[20:16];

  always_ff @(posedge clk) begin
    rf_rdata_a_r <= rf_mem[rd_addr_a];
    rf_rdata_b_r <= rf_mem[rd_addr_b];
    rd_vld_a_r   <= vld_r[rd_addr_a];
    rd_vld_b_r   <= vld_r[rd_addr_b];
    if (commit && wr_eff) begin
      rf_mem[dst] <= val;
    end
  end

  // ---------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------
  assign opc = s2_instr_r[31:26];
  assign rs  = s2_instr_r[25:21];
  assign rt  = s2_instr_r[20:16];
  assign rdi = s2_instr_r[15:11];
  assign fn  = s2_instr_r[5:0];

  // a read that raced with last cycle's write takes the bypassed value
  assign op_a = (byp_valid_r && byp_idx_r == rs) ? byp_val_r :
                (rd_vld_a_r ? rf_rdata_a_r : '0);
  assign op_b = (byp_valid_r && byp_idx_r == rt) ? byp_val_r :
                (rd_vld_b_r ? rf_rdata_b_r : '0);

  assign sext_imm = {{16{s2_instr_r[15]}}, s2_instr_r[15:0]};
  assign pc4      = pc_r + rsis_pkg::PC_STEP;

  always_comb begin
    npc   = pc4;
    wr    = 1'b0;
    taken = 1'b0;
    ok    = 1'b0;
    dst   = '0;
    val   = '0;
    unique case (opc)
      rsis_pkg::OPC_SPECIAL: begin
        unique case (fn)
          rsis_pkg::FN_ADD: begin
            ok  = 1'b1;
            wr  = 1'b1;
            dst = rdi;
            val = op_a + op_b;
          end
          rsis_pkg::FN_AND: begin
            ok  = 1'b1;
            wr  = 1'b1;
            dst = rdi;
            val = op_a & op_b;
          end
          default: ;
        endcase
      end
      rsis_pkg::OPC_ADDI: begin
        ok  = 1'b1;
        wr  = 1'b1;
        dst = rt;
        val = op_a + sext_imm;
      end
      rsis_pkg::OPC_BEQ: begin
        ok = 1'b1;
        if (op_a == op_b) begin
          taken = 1'b1;
          npc   = pc4 + {sext_imm[29:0], 2'b00};
        end
      end
      rsis_pkg::OPC_J: begin
        ok    = 1'b1;
        taken = 1'b1;
        // region of the jump's own address, no +4
        npc   = (pc_r & rsis_pkg::REGION_MASK) | {4'b0000, s2_instr_r[25:0], 2'b00};
      end
      default: ;
    endcase

    // writes to register zero are dropped and reported as no write
    wr_eff = wr && (dst != '0);
    res.next_pc      = npc;
    res.reg_written  = wr_eff;
    res.dest_index   = wr_eff ? dst : '0;
    res.write_value  = wr_eff ? val : '0;
    res.branch_taken = taken;
    res.handled      = ok;
  end

  // ---------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      pc_r        <= rsis_pkg::RESET_VECTOR;
    end else begin
      if (in_fire) begin
        s2_valid_r <= 1'b1;
      end else if (commit) begin
        s2_valid_r <= 1'b0;
      end

      byp_valid_r <= commit && wr_eff;

      if (commit) begin
        out_valid_r <= 1'b1;
        pc_r        <= npc;
        if (wr_eff) begin
          vld_r[dst] <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_instr_r <= in_ch.instr_word;
    end
    if (commit) begin
      out_res_r <= res;
      byp_idx_r <= dst;
      byp_val_r <= val;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_pc      = out_res_r.next_pc;
  assign out_ch.reg_written  = out_res_r.reg_written;
  assign out_ch.dest_index   = out_res_r.dest_index;
  assign out_ch.write_value  = out_res_r.write_value;
  assign out_ch.branch_taken = out_res_r.branch_taken;
  assign out_ch.handled      = out_res_r.handled;

`ifndef SYNTHESIS
  // register zero must never become readable as written
  a_zero_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0])
    else $error("register zero marked written");

  // PC only moves when a result is produced
  a_pc_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(pc_r))
    else $error("PC changed while result stalled");

  // an instruction in execute is never dropped
  a_s2_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !commit) |=> s2_valid_r)
    else $error("execute stage lost an instruction");

  // a committed write is visible to the following instruction through the bypass
  a_bypass_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && wr_eff) |=> (byp_valid_r && byp_idx_r == $past(dst)))
    else $error("bypass not loaded after write");

  // unsupported instructions only step the PC
  a_noop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !ok) |=> (out_res_r.next_pc == $past(pc_r) + rsis_pkg::PC_STEP
                         && !out_res_r.reg_written))
    else $error("no-op did not advance PC by 4");
`endif

endmodule

`default_nettype wire

>>> test/risc_subset_instruction_step_tb.sv
`default_nettype none

module risc_subset_instruction_step_tb;

  // Opcodes and function codes the block treats as no-ops. They are used to hit
  // the fall-through path with realistic words.
  localparam logic [5:0] OPC_JAL   = 6'h03;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;
  localparam logic [5:0] FN_SLL    = 6'h00;
  localparam logic [5:0] FN_UNUSED = 6'h3F;

  localparam int RANDOM_ITEMS    = 1800;
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, forces backpressure
  localparam int QUIET_LIMIT     = 4000;  // cycles with no request moving on either side
  localparam int DRAIN_CYCLES    = 10;    // idle margin after the last result arrives

  logic clk;
  logic rst_n;

  rsis_in_if  in_ch ();
  rsis_out_if out_ch ();

  risc_subset_instruction_step dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Architectural shadow: register file and PC as software would see them.
  // ---------------------------------------------------------------------------
  rsis_pkg::word_t gpr_shadow [rsis_pkg::NUM_REGS] = '{default: '0};
  rsis_pkg::word_t pc_shadow = rsis_pkg::RESET_VECTOR;

  function automatic rsis_pkg::word_t gpr_read(rsis_pkg::reg_idx_t idx);
    return (idx == '0) ? '0 : gpr_shadow[idx];
  endfunction

  function automatic rsis_pkg::word_t sext16(logic [15:0] imm);
    return {{16{imm[15]}}, imm};
  endfunction

  // Executes one instruction on the shadow state and returns the result request
  // the block has to produce for it.
  function automatic rsis_pkg::result_t exec_instr(rsis_pkg::word_t w);
    rsis_pkg::result_t  r;
    logic [5:0]         opc;
    logic [5:0]         fn;
    rsis_pkg::reg_idx_t rs;
    rsis_pkg::reg_idx_t rt;
    rsis_pkg::reg_idx_t rd;
    logic               wr;
    rsis_pkg::word_t    offs;
    opc  = w[31:26];
    fn   = w[5:0];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    wr   = 1'b0;
    offs = sext16(w[15:0]);
    r    = '0;
    r.next_pc = pc_shadow + rsis_pkg::PC_STEP;
    case (opc)
      rsis_pkg::OPC_SPECIAL: begin
        // shamt (bits 10..6) plays no part
        if (fn == rsis_pkg::FN_ADD) begin
          r.handled     = 1'b1;
          wr            = 1'b1;
          r.dest_index  = rd;
          r.write_value = gpr_read(rs) + gpr_read(rt);
        end else if (fn == rsis_pkg::FN_AND) begin
          r.handled     = 1'b1;
          wr            = 1'b1;
          r.dest_index  = rd;
          r.write_value = gpr_read(rs) & gpr_read(rt);
        end
      end
      rsis_pkg::OPC_ADDI: begin
        r.handled     = 1'b1;
        wr            = 1'b1;
        r.dest_index  = rt;
        r.write_value = gpr_read(rs) + offs;
      end
      rsis_pkg::OPC_BEQ: begin
        r.handled = 1'b1;
        if (gpr_read(rs) == gpr_read(rt)) begin
          r.branch_taken = 1'b1;
          r.next_pc      = pc_shadow + rsis_pkg::PC_STEP + {offs[29:0], 2'b00};
        end
      end
      rsis_pkg::OPC_J: begin
        // region of the jump's own address, no +4 afterwards
        r.handled      = 1'b1;
        r.branch_taken = 1'b1;
        r.next_pc      = (pc_shadow & rsis_pkg::REGION_MASK) | {4'b0000, w[25:0], 2'b00};
      end
      default: ;
    endcase
    // writes to r0 are dropped and reported as no write at all
    if (wr && r.dest_index != '0) begin
      gpr_shadow[r.dest_index] = r.write_value;
      r.reg_written = 1'b1;
    end else begin
      r.reg_written = 1'b0;
      r.dest_index  = '0;
      r.write_value = '0;
    end
    pc_shadow = r.next_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Instruction encoders and random picks
  // ---------------------------------------------------------------------------
  function automatic rsis_pkg::word_t enc_r(rsis_pkg::reg_idx_t rs, rsis_pkg::reg_idx_t rt,
                                            rsis_pkg::reg_idx_t rd, logic [4:0] shamt,
                                            logic [5:0] fn);
    return {rsis_pkg::OPC_SPECIAL, rs, rt, rd, shamt, fn};
  endfunction

  function automatic rsis_pkg::word_t enc_i(logic [5:0] opc, rsis_pkg::reg_idx_t rs,
                                            rsis_pkg::reg_idx_t rt, logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic rsis_pkg::word_t enc_j(logic [25:0] target);
    return {rsis_pkg::OPC_J, target};
  endfunction

  function automatic rsis_pkg::result_t mk_result(rsis_pkg::word_t pc, logic wr,
                                                  rsis_pkg::reg_idx_t dst,
                                                  rsis_pkg::word_t val,
                                                  logic taken, logic ok);
    rsis_pkg::result_t r;
    r.next_pc      = pc;
    r.reg_written  = wr;
    r.dest_index   = dst;
    r.write_value  = val;
    r.branch_taken = taken;
    r.handled      = ok;
    return r;
  endfunction

  // At least half the picks land in r0..r3, so hazards and equal BEQ operands are common.
  function automatic rsis_pkg::reg_idx_t pick_reg();
    rsis_pkg::reg_idx_t r;
    r = rsis_pkg::reg_idx_t'($urandom());
    if ($urandom_range(0, 1) == 0) r[4:2] = '0;
    return r;
  endfunction

  function automatic logic [15:0] pick_imm();
    logic [15:0] v;
    v = 16'($urandom());
    case ($urandom_range(0, 7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'hFFFF;
      3: v = 16'h0000;
      default: ;
    endcase
    return v;
  endfunction

  // Mostly well-formed supported ops with random operands; the rest is raw noise,
  // which covers every other opcode, unknown functs and every bit of the word.
  function automatic rsis_pkg::word_t rand_instr();
    int                 sel;
    rsis_pkg::reg_idx_t rs;
    rsis_pkg::reg_idx_t rt;
    rsis_pkg::reg_idx_t rd;
    logic [15:0]        imm;
    rsis_pkg::word_t    raw;
    sel = $urandom_range(0, 99);
    rs  = pick_reg();
    rt  = pick_reg();
    rd  = pick_reg();
    imm = pick_imm();
    raw = $urandom();
    if (sel < 25)      return enc_i(rsis_pkg::OPC_ADDI, rs, rt, imm);
    else if (sel < 45) return enc_r(rs, rt, rd, raw[10:6], rsis_pkg::FN_ADD);
    else if (sel < 60) return enc_r(rs, rt, rd, raw[10:6], rsis_pkg::FN_AND);
    else if (sel < 68) return enc_i(rsis_pkg::OPC_BEQ, rs, rs, imm);   // always taken
    else if (sel < 75) return enc_i(rsis_pkg::OPC_BEQ, rs, rt, imm);
    else if (sel < 83) return enc_j(raw[25:0]);
    else               return raw;
  endfunction

  // Mostly short gaps, a few long ones; none during steady stretches.
  logic steady_phase;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Expectations and mismatch reporting
  // ---------------------------------------------------------------------------
  typedef struct {
    logic              fixed;   // expected result typed in by hand
    rsis_pkg::result_t want;
  } step_plan_t;

  typedef struct {
    rsis_pkg::word_t   instr;
    logic              fixed;
    rsis_pkg::result_t want;
  } step_row_t;

  step_plan_t        plan_q [$];       // one entry per instruction offered, in order
  rsis_pkg::result_t due_results [$];  // results owed by the block, oldest first
  step_row_t         directed_rows [$];
  int                error_count = 0;

  task automatic note_mismatch(string what, rsis_pkg::word_t got, rsis_pkg::word_t want);
    $display("mismatch @%0t: %s got 0x%08h want 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  task automatic add_row(rsis_pkg::word_t w, logic fixed, rsis_pkg::result_t want);
    step_row_t row;
    row.instr = w;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: valid/instr_word change only at rising edges, one NBA each.
  // ---------------------------------------------------------------------------
  task automatic send_instr(rsis_pkg::word_t w, logic fixed, rsis_pkg::result_t want);
    step_plan_t p;
    int         gap;
    p.fixed = fixed;
    p.want  = want;
    gap     = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    plan_q.push_back(p);
    in_ch.valid      <= 1'b1;
    in_ch.instr_word <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready runs and gaps, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  logic hold_off_req;

  initial begin : result_sink
    int   run;
    int   gap;
    logic hold_off_done;
    hold_off_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        run = $urandom_range(1, 20);
        out_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result requests, records instruction requests, and runs the
  // watchdog. Everything is sampled at the rising edge, before the NBA updates.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : monitor
    rsis_pkg::result_t exp_r;
    rsis_pkg::result_t pred_r;
    step_plan_t        p;
    logic              moved;
    moved = 1'b0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result, next_pc", out_ch.next_pc, '0);
      end else begin
        exp_r = due_results.pop_front();
        if (out_ch.next_pc !== exp_r.next_pc)
          note_mismatch("next_pc", out_ch.next_pc, exp_r.next_pc);
        if (out_ch.reg_written !== exp_r.reg_written)
          note_mismatch("reg_written", rsis_pkg::word_t'(out_ch.reg_written),
                        rsis_pkg::word_t'(exp_r.reg_written));
        if (out_ch.dest_index !== exp_r.dest_index)
          note_mismatch("dest_index", rsis_pkg::word_t'(out_ch.dest_index),
                        rsis_pkg::word_t'(exp_r.dest_index));
        if (out_ch.write_value !== exp_r.write_value)
          note_mismatch("write_value", out_ch.write_value, exp_r.write_value);
        if (out_ch.branch_taken !== exp_r.branch_taken)
          note_mismatch("branch_taken", rsis_pkg::word_t'(out_ch.branch_taken),
                        rsis_pkg::word_t'(exp_r.branch_taken));
        if (out_ch.handled !== exp_r.handled)
          note_mismatch("handled", rsis_pkg::word_t'(out_ch.handled),
                        rsis_pkg::word_t'(exp_r.handled));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      moved  = 1'b1;
      p      = plan_q.pop_front();
      // shadow state always advances; hand-typed rows override the prediction
      pred_r = exec_instr(in_ch.instr_word);
      due_results.push_back(p.fixed ? p.want : pred_r);
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rsis_pkg::result_t none;
    none         = '0;
    steady_phase = 1'b0;
    hold_off_req = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.instr_word <= '0;

    // Rows right after reset and the extremes have their results typed in.
    // sll-style all-zero word: unknown funct under SPECIAL
    add_row(32'h0000_0000, 1'b1, mk_result(32'hBFC0_0004, 1'b0, 5'd0, 32'h0, 1'b0, 1'b0));
    // largest positive immediate
    add_row(enc_i(rsis_pkg::OPC_ADDI, 5'd0, 5'd1, 16'h7FFF), 1'b1,
            mk_result(32'hBFC0_0008, 1'b1, 5'd1, 32'h0000_7FFF, 1'b0, 1'b1));
    // most negative immediate
    add_row(enc_i(rsis_pkg::OPC_ADDI, 5'd0, 5'd2, 16'h8000), 1'b1,
            mk_result(32'hBFC0_000C, 1'b1, 5'd2, 32'hFFFF_8000, 1'b0, 1'b1));
    // write to r0 is dropped but still handled
    add_row(enc_i(rsis_pkg::OPC_ADDI, 5'd1, 5'd0, 16'h0005), 1'b1,
            mk_result(32'hBFC0_0010, 1'b0, 5'd0, 32'h0, 1'b0, 1'b1));
    // all-ones word: unsupported opcode
    add_row(32'hFFFF_FFFF, 1'b1, mk_result(32'hBFC0_0014, 1'b0, 5'd0, 32'h0, 1'b0, 1'b0));
    // the rest goes through the shadow model
    add_row(enc_r(5'd1, 5'd2, 5'd3, 5'd0, rsis_pkg::FN_ADD), 1'b0, none);
    add_row(enc_r(5'd2, 5'd3, 5'd4, 5'd0, rsis_pkg::FN_AND), 1'b0, none);
    add_row(enc_i(rsis_pkg::OPC_ADDI, 5'd2, 5'd5, 16'hFFFF), 1'b0, none);
    add_row(enc_i(rsis_pkg::OPC_ADDI, 5'd0, 5'd6, 16'hFFFF), 1'b0, none);
    add_row(enc_r(5'd6, 5'd6, 5'd7, 5'd0, rsis_pkg::FN_ADD), 1'b0, none);     // sum wraps
    add_row(enc_r(5'd6, 5'd7, 5'd8, 5'd31, rsis_pkg::FN_ADD), 1'b0, none);    // shamt ignored
    add_row(enc_r(5'd6, 5'd5, 5'd0, 5'd0, rsis_pkg::FN_AND), 1'b0, none);     // AND into r0
    add_row(enc_r(5'd31, 5'd31, 5'd31, 5'd0, rsis_pkg::FN_ADD), 1'b0, none);  // r31 unwritten
    add_row({rsis_pkg::OPC_SPECIAL, 26'h3FF_FFFF}, 1'b0, none);              // unknown funct
    add_row(enc_r(5'd1, 5'd2, 5'd9, 5'd0, FN_SLL), 1'b0, none);
    add_row(enc_r(5'd1, 5'd2, 5'd9, 5'd0, FN_UNUSED), 1'b0, none);
    add_row(enc_i(rsis_pkg::OPC_BEQ, 5'd0, 5'd0, 16'h7FFF), 1'b0, none);  // taken, far forward
    add_row(enc_i(rsis_pkg::OPC_BEQ, 5'd1, 5'd2, 16'h0010), 1'b0, none);  // not taken
    add_row(enc_i(rsis_pkg::OPC_BEQ, 5'd3, 5'd3, 16'h8000), 1'b0, none);  // taken, far back
    add_row(enc_j(26'h3FF_FFFF), 1'b0, none);
    add_row(enc_j(26'h000_0000), 1'b0, none);
    add_row(enc_i(rsis_pkg::OPC_ADDI, 5'd0, 5'd31, 16'h8000), 1'b0, none);
    add_row(enc_i(OPC_LW, 5'd1, 5'd10, 16'h1234), 1'b0, none);       // load stub
    add_row(enc_i(OPC_SW, 5'd2, 5'd11, 16'hFFFC), 1'b0, none);       // store stub
    add_row({OPC_JAL, 26'h155_5555}, 1'b0, none);                    // JAL is a no-op

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_instr(directed_rows[i].instr, directed_rows[i].fixed, directed_rows[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every fourth stretch of 150 requests runs without idling
      steady_phase = ((i / 150) % 4) == 3;
      // the receiver stalls for a long time while requests keep coming
      if (i == 600) hold_off_req = 1'b1;
      send_instr(rand_instr(), 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    steady_phase = 1'b0;

    // one edge so the monitor has booked the last accepted request
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
